// ----- rtl/jep_pkg.sv -----
// Shared types and constants for the Josephus elimination order block.
package jep_pkg;

    localparam int MAX_POSITIONS_DEF = 256;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int POS_OUT_W  = 8;
    localparam int DVD_CNT_W  = $clog2(CFG_W);

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 1'b1;

    localparam logic [CFG_W-1:0] LIST_LENGTH_RST = 9'd1;
    localparam logic [CFG_W-1:0] STEP_COUNT_RST  = 9'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIV,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [POS_OUT_W-1:0] position;
        logic                 survivor;
        logic                 none_left;
    } result_t;

endpackage

// ----- rtl/jep_ring_mem.sv -----
// Presence map storage: one write port, one read port, registered read data.
module jep_ring_mem #(
    parameter int MAX_POSITIONS = jep_pkg::MAX_POSITIONS_DEF
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(MAX_POSITIONS)-1:0] wr_addr,
    input  logic                             wr_data,
    input  logic [$clog2(MAX_POSITIONS)-1:0] rd_addr,
    output logic                             rd_data
);

    logic mem [MAX_POSITIONS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/jep_ctrl.sv -----
// Sequencer: refill sweep, step remainder, presence scan and removal write-back.
module jep_ctrl #(
    parameter int MAX_POSITIONS = jep_pkg::MAX_POSITIONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             restart,
    input  logic [jep_pkg::CFG_W-1:0]        list_length,
    input  logic [jep_pkg::CFG_W-1:0]        step_count,
    output logic                             busy,
    output logic                             mem_wr_en,
    output logic [$clog2(MAX_POSITIONS)-1:0] mem_wr_addr,
    output logic                             mem_wr_data,
    output logic [$clog2(MAX_POSITIONS)-1:0] mem_rd_addr,
    input  logic                             mem_rd_data,
    output jep_pkg::result_t                 result
);

    localparam int AW = $clog2(MAX_POSITIONS);
    localparam int CW = $clog2(MAX_POSITIONS + 1);
    localparam int LW = (CW > jep_pkg::CFG_W) ? CW : jep_pkg::CFG_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);
    localparam logic [jep_pkg::DVD_CNT_W-1:0] LAST_BIT =
        jep_pkg::DVD_CNT_W'(jep_pkg::CFG_W - 1);

    jep_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  fill_idx_reg, fill_idx_next;
    logic [CW-1:0]                  fill_len_reg, fill_len_next;
    logic                           fill_reply_reg, fill_reply_next;
    logic [CW-1:0]                  remaining_reg, remaining_next;
    logic [AW-1:0]                  cur_reg, cur_next;
    logic [jep_pkg::CFG_W-1:0]      dvd_reg, dvd_next;
    logic [jep_pkg::DVD_CNT_W-1:0]  bit_reg, bit_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic [AW-1:0]                  rd_addr_reg, rd_addr_next;
    logic [AW-1:0]                  pos_reg, pos_next;

    logic                  accept;
    logic [CW-1:0]         len_sat;
    logic [jep_pkg::CFG_W-1:0] step_m1;
    logic [CW:0]           rem_sh;
    logic                  rem_ge;
    logic [CW-1:0]         rem_new;
    logic                  hit;
    logic [AW-1:0]         pos_succ;

    assign accept  = start && (state_reg == jep_pkg::ST_IDLE);
    assign len_sat = (LW'(list_length) > LW'(MAX_POSITIONS)) ?
                     CW'(MAX_POSITIONS) : CW'(list_length);
    // step_count of zero acts as one
    assign step_m1 = (step_count == '0) ? '0 : step_count - 1'b1;

    // restoring remainder, one dividend bit per cycle: (k-1) mod remaining
    assign rem_sh  = {rem_reg, dvd_reg[jep_pkg::CFG_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, remaining_reg};
    assign rem_new = rem_ge ? CW'(rem_sh - {1'b0, remaining_reg}) : CW'(rem_sh);

    assign hit      = rd_vld_reg && mem_rd_data;
    assign pos_succ = (pos_reg == LAST_ADDR) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jep_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        state_next = jep_pkg::ST_FILL;
                    end
                    else if (remaining_reg != '0)
                    begin
                        state_next = jep_pkg::ST_DIV;
                    end
                end
            end
            jep_pkg::ST_FILL:
            begin
                if (fill_idx_reg == LAST_ADDR)
                begin
                    state_next = jep_pkg::ST_IDLE;
                end
            end
            jep_pkg::ST_DIV:
            begin
                if (bit_reg == LAST_BIT)
                begin
                    state_next = jep_pkg::ST_SCAN;
                end
            end
            jep_pkg::ST_SCAN:
            begin
                if (hit && cnt_reg == '0)
                begin
                    state_next = jep_pkg::ST_WRITE;
                end
            end
            jep_pkg::ST_WRITE:
            begin
                state_next = jep_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = jep_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy            = state_reg != jep_pkg::ST_IDLE;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pos_reg;
        mem_wr_data     = 1'b0;
        mem_rd_addr     = addr_reg;
        result          = '0;
        fill_idx_next   = fill_idx_reg;
        fill_len_next   = fill_len_reg;
        fill_reply_next = fill_reply_reg;
        remaining_next  = remaining_reg;
        cur_next        = cur_reg;
        dvd_next        = dvd_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        rd_vld_next     = 1'b0;
        rd_addr_next    = rd_addr_reg;
        pos_next        = pos_reg;
        case (state_reg)
            jep_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        fill_idx_next   = '0;
                        fill_len_next   = len_sat;
                        fill_reply_next = 1'b1;
                    end
                    else if (remaining_reg == '0)
                    begin
                        result.valid     = 1'b1;
                        result.none_left = 1'b1;
                    end
                    else
                    begin
                        dvd_next = step_m1;
                        bit_next = '0;
                        rem_next = '0;
                    end
                end
            end
            jep_pkg::ST_FILL:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = fill_idx_reg;
                mem_wr_data   = CW'(fill_idx_reg) < fill_len_reg;
                fill_idx_next = fill_idx_reg + 1'b1;
                if (fill_idx_reg == LAST_ADDR)
                begin
                    fill_idx_next    = '0;
                    remaining_next   = fill_len_reg;
                    cur_next         = '0;
                    result.valid     = fill_reply_reg;
                    result.none_left = 1'b1;
                end
            end
            jep_pkg::ST_DIV:
            begin
                rem_next = rem_new;
                dvd_next = dvd_reg << 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == LAST_BIT)
                begin
                    cnt_next  = rem_new;
                    addr_next = cur_reg;
                end
            end
            jep_pkg::ST_SCAN:
            begin
                // reads stream one address per cycle; the read data comes back registered
                mem_rd_addr  = addr_reg;
                addr_next    = (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;
                rd_vld_next  = 1'b1;
                rd_addr_next = addr_reg;
                if (hit)
                begin
                    if (cnt_reg == '0)
                    begin
                        pos_next    = rd_addr_reg;
                        rd_vld_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            jep_pkg::ST_WRITE:
            begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = pos_reg;
                mem_wr_data     = 1'b0;
                remaining_next  = remaining_reg - 1'b1;
                // next scan skips absent entries, so the successor slot will do
                cur_next        = (remaining_reg == CW'(1)) ? '0 : pos_succ;
                result.valid    = 1'b1;
                result.position = jep_pkg::POS_OUT_W'(pos_reg);
                result.survivor = remaining_reg == CW'(1);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= jep_pkg::ST_FILL;
            fill_idx_reg   <= '0;
            fill_len_reg   <= CW'(jep_pkg::LIST_LENGTH_RST);
            fill_reply_reg <= 1'b0;
            remaining_reg  <= '0;
            cur_reg        <= '0;
            bit_reg        <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_idx_reg   <= fill_idx_next;
            fill_len_reg   <= fill_len_next;
            fill_reply_reg <= fill_reply_next;
            remaining_reg  <= remaining_next;
            cur_reg        <= cur_next;
            bit_reg        <= bit_next;
            rd_vld_reg     <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        addr_reg    <= addr_next;
        rd_addr_reg <= rd_addr_next;
        pos_reg     <= pos_next;
    end

endmodule

// ----- rtl/josephus_elimination_order.sv -----
// Top level: configuration registers, result registers, sequencer and presence map.
//
// Usage:
//   Requests enter on start/restart; a request is taken at a rising edge with start
//   high and busy low. restart=1 refills the ring with list_length positions, restart=0
//   removes the next position, counting step_count present positions from the current
//   point. Every request gives one result, shown for one cycle with done high; the
//   receiver cannot stall it, so it must sample removed_position, is_survivor and
//   none_left in that cycle.
//   Configuration: cfg_wr_en, cfg_index, cfg_data write list_length (index 0) or
//   step_count (index 1) at once; write only while busy is low and no result is due.
// Operation:
//   Empty ring: done is registered from the request, busy stays low.
//   Restart: a refill sweep writes one map entry per cycle over the whole map;
//   done follows the sweep.
//   Removal: a restoring remainder over the step count, one bit at a time, then a scan
//   of the map at one entry per cycle through its single read port until the target is
//   found, then a write-back clears that entry; done follows in the next cycle.
// Reset: rst_n clears control state and starts the same refill sweep (list_length 1,
//   step_count 2); busy is high during the sweep and no result is given.
module josephus_elimination_order #(
    parameter int MAX_POSITIONS = jep_pkg::MAX_POSITIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              restart,
    input  logic                              cfg_wr_en,
    input  logic [jep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jep_pkg::CFG_W-1:0]         cfg_data,
    output logic                              done,
    output logic [jep_pkg::POS_OUT_W-1:0]     removed_position,
    output logic                              is_survivor,
    output logic                              none_left
);

    localparam int AW = $clog2(MAX_POSITIONS);

    logic [jep_pkg::CFG_W-1:0] list_length_reg;
    logic [jep_pkg::CFG_W-1:0] step_count_reg;

    logic                  done_reg;
    logic [jep_pkg::POS_OUT_W-1:0] removed_reg;
    logic                  survivor_reg;
    logic                  none_reg;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic          mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic          mem_rd_data;
    jep_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= jep_pkg::LIST_LENGTH_RST;
            step_count_reg  <= jep_pkg::STEP_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                jep_pkg::CFG_LIST_LENGTH: list_length_reg <= cfg_data;
                jep_pkg::CFG_STEP_COUNT:  step_count_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg  <= result.position;
        survivor_reg <= result.survivor;
        none_reg     <= result.none_left;
    end

    assign done             = done_reg;
    assign removed_position = removed_reg;
    assign is_survivor      = survivor_reg;
    assign none_left        = none_reg;

    jep_ctrl #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .restart     (restart),
        .list_length (list_length_reg),
        .step_count  (step_count_reg),
        .busy        (busy),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .result      (result)
    );

    jep_ring_mem #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ----- rtl/jep_checker.sv -----
// Port-level checks for the Josephus elimination order block, bound to the top level.
module jep_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          restart,
    input logic                          done,
    input logic [jep_pkg::POS_OUT_W-1:0] removed_position,
    input logic                          is_survivor,
    input logic                          none_left
);

    // a result only follows a taken request or work in progress
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without a request");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_survivor && none_left))
        else $error("survivor and empty flags both set");

    a_empty_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && none_left) |-> (removed_position == '0))
        else $error("empty or restart result carries a position");

    // a restart always runs the refill sweep
    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && restart) |=> (busy && !done))
        else $error("restart did not start the refill sweep");

endmodule

bind josephus_elimination_order jep_checker u_jep_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .restart          (restart),
    .done             (done),
    .removed_position (removed_position),
    .is_survivor      (is_survivor),
    .none_left        (none_left)
);
